// ----- sv/lbo_pkg.sv -----
// ----------------------------------------------------------------------------
// lbo_pkg
// Shared types and constants for the LED blink / one-shot controller.
// ----------------------------------------------------------------------------
package lbo_pkg;

   localparam int NUM_LEDS  = 3;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 16;
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 2;
   localparam int LEVELS_W  = 3;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 3;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ON    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OFF   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_BLINK = 2'd3;

   localparam logic REG_PULSE_LENGTH   = 1'b0;
   localparam logic REG_BLINK_INTERVAL = 1'b1;

   localparam logic [CFG_W-1:0] PULSE_LENGTH_RST   = 16'd50;
   localparam logic [CFG_W-1:0] BLINK_INTERVAL_RST = 16'd250;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] led_index;
      logic             oneshot;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0] pulse_length;
      logic [CFG_W-1:0] blink_interval;
   } cfg_type;

endpackage

// ----- sv/lbo_csr.sv -----
// ----------------------------------------------------------------------------
// lbo_csr
// Configuration registers: pulse length and blink interval, APB-style access.
// ----------------------------------------------------------------------------
module lbo_csr
   import lbo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [CFG_W-1:0] pulse_length_ff;
   logic [CFG_W-1:0] pulse_length_in;
   logic [CFG_W-1:0] blink_interval_ff;
   logic [CFG_W-1:0] blink_interval_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      pulse_length_in   = pulse_length_ff;
      blink_interval_in = blink_interval_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_PULSE_LENGTH:   pulse_length_in   = csr_pwdata[CFG_W-1:0];
            REG_BLINK_INTERVAL: blink_interval_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_length_ff   <= PULSE_LENGTH_RST;
         blink_interval_ff <= BLINK_INTERVAL_RST;
      end else begin
         pulse_length_ff   <= pulse_length_in;
         blink_interval_ff <= blink_interval_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PULSE_LENGTH:   csr_prdata = DATA_W'(pulse_length_ff);
         REG_BLINK_INTERVAL: csr_prdata = DATA_W'(blink_interval_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.pulse_length   = pulse_length_ff;
   assign cfg.blink_interval = blink_interval_ff;

endmodule

// ----- sv/lbo_core.sv -----
// ----------------------------------------------------------------------------
// lbo_core
// LED state: time counter, blink phase, per-LED blink flag, deadline, level.
// Applies one command per fire and presents the updated level vector.
// ----------------------------------------------------------------------------
module lbo_core
   import lbo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  item_type            item,
   input  cfg_type             cfg,
   output logic [LEVELS_W-1:0] levels
);

   logic [TIME_W-1:0]   time_ff;
   logic [TIME_W-1:0]   time_in;
   logic [TIME_W-1:0]   last_ff;
   logic [TIME_W-1:0]   last_in;
   logic                phase_ff;
   logic                phase_in;
   logic [NUM_LEDS-1:0] en_ff;
   logic [NUM_LEDS-1:0] en_in;
   logic [NUM_LEDS-1:0] lvl_ff;
   logic [NUM_LEDS-1:0] lvl_in;
   logic [TIME_W-1:0]   dl_ff [NUM_LEDS];
   logic [TIME_W-1:0]   dl_in [NUM_LEDS];
   logic [TIME_W-1:0]   deadline;
   logic [TIME_W-1:0]   toggle_at;

   assign deadline  = time_ff + TIME_W'(cfg.pulse_length);
   assign toggle_at = last_ff + TIME_W'(cfg.blink_interval);

   always_comb begin
      time_in  = time_ff;
      last_in  = last_ff;
      phase_in = phase_ff;
      en_in    = en_ff;
      lvl_in   = lvl_ff;
      dl_in    = dl_ff;
      if (fire) begin
         if (item.cmd == CMD_TICK) begin
            time_in = time_ff + TIME_W'(1);
            for (int i = 0; i < NUM_LEDS; i++) begin
               if (en_ff[i] && (dl_ff[i] != '0) && (dl_ff[i] < time_in)) begin
                  lvl_in[i] = 1'b0;
                  dl_in[i]  = '0;
                  en_in[i]  = 1'b0;
               end
            end
            if (time_in > toggle_at) begin
               phase_in = ~phase_ff;
               last_in  = time_in;
               for (int i = 0; i < NUM_LEDS; i++) begin
                  if (en_in[i] && (dl_in[i] == '0)) begin
                     lvl_in[i] = phase_in;
                  end
               end
            end
         end else begin
            for (int i = 0; i < NUM_LEDS; i++) begin
               if (32'(item.led_index) == i) begin
                  case (item.cmd)
                     CMD_ON: begin
                        en_in[i]  = 1'b0;
                        lvl_in[i] = 1'b1;
                     end
                     CMD_OFF: begin
                        en_in[i]  = 1'b0;
                        lvl_in[i] = 1'b0;
                     end
                     CMD_BLINK: begin
                        en_in[i] = 1'b1;
                        if (item.oneshot) begin
                           dl_in[i]  = deadline;
                           lvl_in[i] = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         last_ff  <= '0;
         phase_ff <= 1'b0;
         en_ff    <= '0;
         lvl_ff   <= '0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            dl_ff[i] <= '0;
         end
      end else begin
         time_ff  <= time_in;
         last_ff  <= last_in;
         phase_ff <= phase_in;
         en_ff    <= en_in;
         lvl_ff   <= lvl_in;
         dl_ff    <= dl_in;
      end
   end

   assign levels = LEVELS_W'(lvl_in);

endmodule

// ----- sv/led_blink_oneshot_controller_unit.sv -----
// ----------------------------------------------------------------------------
// led_blink_oneshot_controller_unit
// Command-driven LED controller with shared blink phase and one-shot pulses.
//
//   channel  direction  word                          handshake
//   req      in         cmd, led_index, oneshot       req_valid / req_stall
//   rsp      out        led_levels                    rsp_valid / rsp_stall
//   csr      in/out     pulse_length, blink_interval  APB-style, pready high
//
// One word is accepted per cycle while req_stall is low; its result passes
// through the input register, then the result register through the state update.
// Reset clears the input and result stages and all LED state, and loads
// pulse_length 50 and blink_interval 250.
// A stalled result holds; the input register keeps taking words until it
// is full behind that result, then req_stall rises.
// ----------------------------------------------------------------------------
module led_blink_oneshot_controller_unit
   import lbo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_led_index,
   input  logic                req_oneshot,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LEVELS_W-1:0] rsp_led_levels,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   cfg_type             cfg;
   item_type            item_ff;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [LEVELS_W-1:0] result_ff;
   logic [LEVELS_W-1:0] levels;
   logic                advance;
   logic                take;

   lbo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lbo_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .levels (levels)
   );

   assign advance      = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = in_valid_ff & ~advance;
   assign take         = req_valid & ~req_stall;
   assign in_valid_in  = take | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.cmd       <= req_cmd;
         item_ff.led_index <= req_led_index;
         item_ff.oneshot   <= req_oneshot;
      end
      if (advance) begin
         result_ff <= levels;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_levels = result_ff;

endmodule

// ----- test/led_levels_checker.sv -----
// ----------------------------------------------------------------------------
// led_levels_checker
// Watches the command, result and register channels of the LED controller.
// Keeps its own copy of the time, blink phase, deadlines and LED levels,
// works out the level vector owed for every accepted command word, and
// compares each accepted result with the oldest one owed. Reports the number
// of words still owed and the number of failures.
// ----------------------------------------------------------------------------
module led_levels_checker
   import lbo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [IDX_W-1:0]    req_led_index,
   input  logic                req_oneshot,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [LEVELS_W-1:0] rsp_led_levels,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic                csr_pready,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output int                  pending,
   output int                  failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ADDR_W-1:0] PULSE_ADDR    = {REG_PULSE_LENGTH, 2'b00};
   localparam logic [ADDR_W-1:0] INTERVAL_ADDR = {REG_BLINK_INTERVAL, 2'b00};

   cfg_type             cfg;
   logic [TIME_W-1:0]   now_ticks;
   logic [TIME_W-1:0]   last_flip;
   logic                phase;
   logic [NUM_LEDS-1:0] blinking;
   logic [NUM_LEDS-1:0] lit;
   logic [TIME_W-1:0]   deadline [NUM_LEDS];
   logic [LEVELS_W-1:0] levels_due [$];
   int                  mismatches = 0;

   task automatic advance_leds(input item_type w, output logic [LEVELS_W-1:0] lv);
      logic [TIME_W-1:0] flip_at;
      if (w.cmd == CMD_TICK) begin
         now_ticks = now_ticks + 1'b1;
         for (int i = 0; i < NUM_LEDS; i++) begin
            if (blinking[i] && deadline[i] != '0 && deadline[i] < now_ticks) begin
               lit[i]      = 1'b0;
               deadline[i] = '0;
               blinking[i] = 1'b0;
            end
         end
         flip_at = last_flip + TIME_W'(cfg.blink_interval);
         if (now_ticks > flip_at) begin
            phase     = ~phase;
            last_flip = now_ticks;
            for (int i = 0; i < NUM_LEDS; i++) begin
               if (blinking[i] && deadline[i] == '0) begin
                  lit[i] = phase;
               end
            end
         end
      end else if (w.led_index < NUM_LEDS) begin
         case (w.cmd)
            CMD_ON: begin
               blinking[w.led_index] = 1'b0;
               lit[w.led_index]      = 1'b1;
            end
            CMD_OFF: begin
               blinking[w.led_index] = 1'b0;
               lit[w.led_index]      = 1'b0;
            end
            CMD_BLINK: begin
               blinking[w.led_index] = 1'b1;
               if (w.oneshot) begin
                  deadline[w.led_index] = now_ticks + TIME_W'(cfg.pulse_length);
                  lit[w.led_index]      = 1'b1;
               end
            end
            default: ;
         endcase
      end
      lv = '0;
      for (int i = 0; i < NUM_LEDS && i < LEVELS_W; i++) begin
         lv[i] = lit[i];
      end
   endtask

   always @(posedge clock) begin
      item_type            w;
      logic [LEVELS_W-1:0] lv;
      logic [LEVELS_W-1:0] due;
      if (reset) begin
         cfg.pulse_length   = PULSE_LENGTH_RST;
         cfg.blink_interval = BLINK_INTERVAL_RST;
         now_ticks          = '0;
         last_flip          = '0;
         phase              = 1'b0;
         blinking           = '0;
         lit                = '0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            deadline[i] = '0;
         end
         levels_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == PULSE_ADDR) begin
               cfg.pulse_length = csr_pwdata[CFG_W-1:0];
            end else if (csr_paddr == INTERVAL_ADDR) begin
               cfg.blink_interval = csr_pwdata[CFG_W-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            w.cmd       = req_cmd;
            w.led_index = req_led_index;
            w.oneshot   = req_oneshot;
            advance_leds(w, lv);
            levels_due.push_back(lv);
         end
         if (rsp_valid && !rsp_stall) begin
            if (levels_due.size() == 0) begin
               $error("led_levels: unexpected result, actual %0h", rsp_led_levels);
               mismatches++;
            end else begin
               due = levels_due.pop_front();
               if (rsp_led_levels !== due) begin
                  $error("led_levels mismatch: expected %0h, actual %0h",
                         due, rsp_led_levels);
                  mismatches++;
               end
            end
         end
      end
      pending  <= levels_due.size();
      failures <= mismatches;
   end

endmodule

// ----- test/tb_led_blink_oneshot_controller_unit.sv -----
// ----------------------------------------------------------------------------
// tb_led_blink_oneshot_controller_unit
// Drives command words into the LED controller: a directed run over on, off,
// blink, one-shot, out-of-range LEDs, pulse expiry and stale deadlines, then
// random bursts under several register settings, the extremes among them.
// The result side stalls on its own pattern, with one long hold that backs
// the block up. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_led_blink_oneshot_controller_unit;
   import lbo_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ADDR_W-1:0] PULSE_ADDR    = {REG_PULSE_LENGTH, 2'b00};
   localparam logic [ADDR_W-1:0] INTERVAL_ADDR = {REG_BLINK_INTERVAL, 2'b00};
   localparam int HOLD_CYCLES  = 48;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SEGMENTS     = 5;
   localparam int SEG_WORDS    = 80;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [IDX_W-1:0]    req_led_index;
   logic                req_oneshot;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [LEVELS_W-1:0] rsp_led_levels;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;
   int                  pending;
   int                  failures;
   int                  holds_wanted = 0;
   int                  holds_done = 0;
   int                  cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   led_blink_oneshot_controller_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_led_index  (req_led_index),
      .req_oneshot    (req_oneshot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_levels (rsp_led_levels),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   led_levels_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_led_index  (req_led_index),
      .req_oneshot    (req_oneshot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_levels (rsp_led_levels),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .pending        (pending),
      .failures       (failures)
   );

   function automatic item_type random_word();
      item_type w;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         w.cmd = CMD_TICK;
      end else if (pick < 55) begin
         w.cmd = CMD_ON;
      end else if (pick < 65) begin
         w.cmd = CMD_OFF;
      end else begin
         w.cmd = CMD_BLINK;
      end
      if ($urandom_range(0, 9) == 0) begin
         w.led_index = IDX_W'(3);
      end else begin
         w.led_index = IDX_W'($urandom_range(0, NUM_LEDS - 1));
      end
      w.oneshot = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // offer one word, return at the edge that takes it with valid still high
   task automatic send_word(input item_type w);
      req_valid     <= 1'b1;
      req_cmd       <= w.cmd;
      req_led_index <= w.led_index;
      req_oneshot   <= w.oneshot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic put(input logic [CMD_W-1:0] cmd, input int idx, input logic os);
      item_type w;
      w.cmd       = cmd;
      w.led_index = IDX_W'(idx);
      w.oneshot   = os;
      send_word(w);
   endtask

   task automatic go_idle(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // result side: random stall patterns, plus a long hold on request
   initial begin
      int mode;
      int span;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (holds_done < holds_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            while (span > 0 && holds_done == holds_wanted) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ~rsp_stall;
                  default: rsp_stall <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
               span--;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] seg_pulse [SEGMENTS];
      logic [CFG_W-1:0] seg_interval [SEGMENTS];
      int               sent;
      int               burst;
      seg_pulse[0]    = 16'd1;
      seg_interval[0] = 16'd1;
      seg_pulse[1]    = 16'hFFFF;
      seg_interval[1] = 16'hFFFF;
      seg_pulse[2]    = CFG_W'($urandom_range(1, 8));
      seg_interval[2] = CFG_W'($urandom_range(1, 6));
      seg_pulse[3]    = 16'd3;
      seg_interval[3] = 16'd2;
      seg_pulse[4]    = CFG_W'($urandom_range(1, 30));
      seg_interval[4] = CFG_W'($urandom_range(1, 12));

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_TICK;
      req_led_index <= '0;
      req_oneshot   <= 1'b0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: plain on/off, out-of-range LED, ignored fields on tick
      put(CMD_ON, 0, 1'b0);
      put(CMD_ON, 1, 1'b1);
      put(CMD_ON, 2, 1'b0);
      put(CMD_ON, 3, 1'b0);
      go_idle(2);
      put(CMD_BLINK, 3, 1'b1);
      put(CMD_OFF, 3, 1'b1);
      put(CMD_TICK, 3, 1'b1);
      put(CMD_OFF, 0, 1'b0);
      go_idle(1);
      put(CMD_OFF, 1, 1'b1);
      put(CMD_OFF, 2, 1'b0);
      wait_drained();

      // shortest pulse and interval: expiry, flips, stale deadline
      write_csr(PULSE_ADDR, 16'd1);
      write_csr(INTERVAL_ADDR, 16'd1);
      put(CMD_BLINK, 0, 1'b1);
      put(CMD_BLINK, 1, 1'b0);
      put(CMD_TICK, 0, 1'b0);
      put(CMD_TICK, 2, 1'b0);
      put(CMD_TICK, 1, 1'b1);
      put(CMD_BLINK, 2, 1'b1);
      put(CMD_ON, 2, 1'b0);
      go_idle(3);
      put(CMD_BLINK, 2, 1'b0);
      put(CMD_TICK, 0, 1'b0);
      put(CMD_TICK, 0, 1'b0);
      put(CMD_TICK, 0, 1'b0);
      put(CMD_OFF, 1, 1'b0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained();
         write_csr(PULSE_ADDR, seg_pulse[seg]);
         write_csr(INTERVAL_ADDR, seg_interval[seg]);
         if (seg == 1) begin
            holds_wanted++;
         end
         sent = 0;
         while (sent < SEG_WORDS) begin
            if (seg == 1 && sent == 0) begin
               burst = 30;
            end else if ($urandom_range(0, 5) == 0) begin
               burst = $urandom_range(16, 40);
            end else begin
               burst = $urandom_range(1, 12);
            end
            for (int b = 0; b < burst; b++) begin
               send_word(random_word());
               sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
               wait_drained();
            end else begin
               go_idle($urandom_range(1, 6));
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
